// ----- design/speaker_segment_tracker_assert.svh -----
// ----------------------------------------------------------------------------
// speaker_segment_tracker_assert.svh
// Assertion macros shared by the speaker segment tracker RTL.
// ----------------------------------------------------------------------------
`ifndef SPEAKER_SEGMENT_TRACKER_ASSERT_SVH
`define SPEAKER_SEGMENT_TRACKER_ASSERT_SVH

// checked only while out of reset
`define SST_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define SST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/ssegt_pkg.sv -----
// ----------------------------------------------------------------------------
// ssegt_pkg
// Types and constants of the speaker segment tracker.
// ----------------------------------------------------------------------------
package ssegt_pkg;

  localparam int NumClasses = 7;
  localparam int NumScores  = 7;
  localparam int MaxFrames  = 1024;

  localparam int ScoreW = 16;
  localparam int FrameW = $clog2(MaxFrames + 1);
  localparam int ClassW = 3;
  localparam int SpkW   = 4;
  localparam int MinW   = 11;
  localparam int CfgW   = 16;
  localparam int CfgIdxW = 1;

  localparam logic [SpkW-1:0]          NoneSpk     = 4'd15;
  localparam logic signed [ScoreW-1:0] ThreshReset = -16'sd217;
  localparam logic [MinW-1:0]          MinSegReset = 11'd29;

  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = 2;
  localparam int FifoCntW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ACT_THRESH = 1'b0,
    REG_MIN_SEG    = 1'b1
  } cfg_reg_e;

  typedef logic signed [ScoreW-1:0] score_t;

  typedef struct packed {
    logic [FrameW-1:0] start_frame;
    logic [FrameW-1:0] end_frame;
    logic [ClassW-1:0] spk;
    logic              last;
  } seg_t;

  typedef struct packed {
    logic [1:0] cnt;
    seg_t       a;
    seg_t       b;
  } push_t;

endpackage

// ----- design/ssegt_in_if.sv -----
// ----------------------------------------------------------------------------
// ssegt_in_if
// Frame channel: seven class logits and the end-of-chunk flag.
// ----------------------------------------------------------------------------
interface ssegt_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] score_0;
  logic signed [15:0] score_1;
  logic signed [15:0] score_2;
  logic signed [15:0] score_3;
  logic signed [15:0] score_4;
  logic signed [15:0] score_5;
  logic signed [15:0] score_6;
  logic               end_of_chunk;

  modport source (output valid, score_0, score_1, score_2, score_3, score_4, score_5,
                  score_6, end_of_chunk, input ready);
  modport sink (input valid, score_0, score_1, score_2, score_3, score_4, score_5,
                score_6, end_of_chunk, output ready);
endinterface

// ----- design/ssegt_out_if.sv -----
// ----------------------------------------------------------------------------
// ssegt_out_if
// Segment channel: start, end (exclusive), speaker and last-of-run flag.
// ----------------------------------------------------------------------------
interface ssegt_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] seg_start_frame;
  logic [10:0] seg_end_frame;
  logic [2:0]  speaker_class;
  logic        last_of_run;

  modport source (output valid, seg_start_frame, seg_end_frame, speaker_class,
                  last_of_run, input ready);
  modport sink (input valid, seg_start_frame, seg_end_frame, speaker_class,
                last_of_run, output ready);
endinterface

// ----- design/ssegt_argmax.sv -----
// ----------------------------------------------------------------------------
// ssegt_argmax
// First-index argmax over the class logits with silence threshold.
// ----------------------------------------------------------------------------
module ssegt_argmax (
  input  ssegt_pkg::score_t                scores_i [ssegt_pkg::NumScores],
  input  ssegt_pkg::score_t                thresh_i,
  output logic [ssegt_pkg::SpkW-1:0]       winner_o
);

  ssegt_pkg::score_t               best;
  logic [ssegt_pkg::ClassW-1:0]    win;

  always_comb begin
    best = scores_i[0];
    win  = '0;
    for (int c = 1; c < ssegt_pkg::NumClasses; c++) begin
      if (scores_i[c] > best) begin
        best = scores_i[c];
        win  = ssegt_pkg::ClassW'(c);
      end
    end
    winner_o = (best < thresh_i) ? ssegt_pkg::NoneSpk : ssegt_pkg::SpkW'(win);
  end

endmodule

// ----- design/ssegt_tracker.sv -----
// ----------------------------------------------------------------------------
// ssegt_tracker
// Input register, config registers and segment tracking state.
// ----------------------------------------------------------------------------
`include "speaker_segment_tracker_assert.svh"

module ssegt_tracker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ssegt_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ssegt_pkg::CfgW-1:0]        cfg_data_i,
  ssegt_in_if.sink                          frame_i,
  input  logic                              room_i,
  output ssegt_pkg::push_t                  push_o
);

  logic                              s1_valid_q, s1_valid_d;
  ssegt_pkg::score_t                 s1_scores_q [ssegt_pkg::NumScores];
  logic                              s1_eoc_q;
  ssegt_pkg::score_t                 thr_q;
  logic [ssegt_pkg::MinW-1:0]        min_q;
  logic [ssegt_pkg::FrameW-1:0]      fc_q, fc_d, fc_inc;
  logic [ssegt_pkg::SpkW-1:0]        spk_q, spk_d, spk_mid;
  logic [ssegt_pkg::FrameW-1:0]      beg_q, beg_d, beg_mid;
  logic [ssegt_pkg::SpkW-1:0]        winner;
  logic                              take, fire, change, emit0, emit1;
  ssegt_pkg::seg_t                   r0, r1;

  assign fire          = s1_valid_q && room_i;
  assign frame_i.ready = !s1_valid_q || fire;
  assign take          = frame_i.valid && frame_i.ready;
  assign s1_valid_d    = take ? 1'b1 : (fire ? 1'b0 : s1_valid_q);

  ssegt_argmax u_argmax (
    .scores_i (s1_scores_q),
    .thresh_i (thr_q),
    .winner_o (winner)
  );

  always_comb begin
    change  = winner != spk_q;
    emit0   = change && (spk_q != ssegt_pkg::NoneSpk) && ((fc_q - beg_q) > min_q);
    spk_mid = change ? winner : spk_q;
    beg_mid = change ? fc_q : beg_q;
    fc_inc  = (fc_q < ssegt_pkg::FrameW'(ssegt_pkg::MaxFrames)) ? fc_q + 1'b1 : fc_q;
    emit1   = s1_eoc_q && (spk_mid != ssegt_pkg::NoneSpk);

    r0.start_frame = beg_q;
    r0.end_frame   = fc_q;
    r0.spk         = spk_q[ssegt_pkg::ClassW-1:0];
    r0.last        = !emit1;
    r1.start_frame = beg_mid;
    r1.end_frame   = fc_inc;
    r1.spk         = spk_mid[ssegt_pkg::ClassW-1:0];
    r1.last        = 1'b1;

    push_o.cnt = fire ? ({1'b0, emit0} + {1'b0, emit1}) : 2'd0;
    push_o.a   = emit0 ? r0 : r1;
    push_o.b   = r1;

    if (s1_eoc_q) begin
      fc_d  = '0;
      spk_d = ssegt_pkg::NoneSpk;
      beg_d = '0;
    end else begin
      fc_d  = fc_inc;
      spk_d = spk_mid;
      beg_d = beg_mid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      thr_q      <= ssegt_pkg::ThreshReset;
      min_q      <= ssegt_pkg::MinSegReset;
      fc_q       <= '0;
      spk_q      <= ssegt_pkg::NoneSpk;
      beg_q      <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (cfg_we_i) begin
        case (ssegt_pkg::cfg_reg_e'(cfg_idx_i))
          ssegt_pkg::REG_ACT_THRESH: thr_q <= signed'(cfg_data_i);
          ssegt_pkg::REG_MIN_SEG:    min_q <= cfg_data_i[ssegt_pkg::MinW-1:0];
          default: ;
        endcase
      end
      if (fire) begin
        fc_q  <= fc_d;
        spk_q <= spk_d;
        beg_q <= beg_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_scores_q[0] <= frame_i.score_0;
      s1_scores_q[1] <= frame_i.score_1;
      s1_scores_q[2] <= frame_i.score_2;
      s1_scores_q[3] <= frame_i.score_3;
      s1_scores_q[4] <= frame_i.score_4;
      s1_scores_q[5] <= frame_i.score_5;
      s1_scores_q[6] <= frame_i.score_6;
      s1_eoc_q       <= frame_i.end_of_chunk;
    end
  end

  `SST_ASSERT(a_spk_legal, clk_i, rst_ni,
    (spk_q == ssegt_pkg::NoneSpk) || (spk_q < ssegt_pkg::SpkW'(ssegt_pkg::NumClasses)),
    "tracked speaker out of range")
  `SST_ASSERT(a_beg_le_fc, clk_i, rst_ni, beg_q <= fc_q, "segment begins after frame count")
  `SST_ASSERT(a_eoc_clears, clk_i, rst_ni,
    (fire && s1_eoc_q) |=> (fc_q == '0 && spk_q == ssegt_pkg::NoneSpk && beg_q == '0),
    "end of chunk did not clear tracker")

endmodule

// ----- design/ssegt_out_fifo.sv -----
// ----------------------------------------------------------------------------
// ssegt_out_fifo
// Four-entry result queue, up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
`include "speaker_segment_tracker_assert.svh"

module ssegt_out_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ssegt_pkg::push_t     push_i,
  output logic                 room_o,
  ssegt_out_if.source          seg_o
);

  ssegt_pkg::seg_t                     mem [ssegt_pkg::FifoDepth];
  logic [ssegt_pkg::FifoPtrW-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [ssegt_pkg::FifoCntW-1:0]      cnt_q, cnt_d;
  logic                                pop;
  ssegt_pkg::seg_t                     head;

  assign room_o = cnt_q <= ssegt_pkg::FifoCntW'(ssegt_pkg::FifoDepth - 2);
  assign pop    = seg_o.valid && seg_o.ready;
  assign head   = mem[rd_q];

  assign seg_o.valid           = cnt_q != '0;
  assign seg_o.seg_start_frame = head.start_frame;
  assign seg_o.seg_end_frame   = head.end_frame;
  assign seg_o.speaker_class   = head.spk;
  assign seg_o.last_of_run     = head.last;

  always_comb begin
    wr_d  = wr_q + ssegt_pkg::FifoPtrW'(push_i.cnt);
    rd_d  = rd_q + ssegt_pkg::FifoPtrW'(pop);
    cnt_d = cnt_q + ssegt_pkg::FifoCntW'(push_i.cnt) - ssegt_pkg::FifoCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem[wr_q] <= push_i.a;
    end
    if (push_i.cnt == 2'd2) begin
      mem[wr_q + 1'b1] <= push_i.b;
    end
  end

  `SST_ASSERT_ALWAYS(a_cnt_bound, clk_i,
    cnt_q <= ssegt_pkg::FifoCntW'(ssegt_pkg::FifoDepth), "result queue count overflow")
  `SST_ASSERT(a_push_room, clk_i, rst_ni, (push_i.cnt != 2'd0) |-> room_o,
    "push without room")
  `SST_ASSERT(a_cnt_two, clk_i, rst_ni, (push_i.cnt == 2'd2 && !pop) |=>
    (cnt_q == $past(cnt_q) + 3'd2), "double push lost an entry")

endmodule

// ----- design/speaker_segment_tracker.sv -----
// ----------------------------------------------------------------------------
// speaker_segment_tracker
// Argmax/threshold speaker segmenter over frames of class logits.
// A frame passes the frame register, then the result queue.
// Throughput: 1 frame per cycle while the result queue has room; the two
// segments of one frame leave one at a time through the single read port
// of the 4-entry result queue.
// Reset: threshold -217, min length 29, frame count 0, no active speaker.
// ----------------------------------------------------------------------------
module speaker_segment_tracker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ssegt_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ssegt_pkg::CfgW-1:0]        cfg_data_i,
  ssegt_in_if.sink                          frame_i,
  ssegt_out_if.source                       seg_o
);

  ssegt_pkg::push_t push;
  logic             room;

  ssegt_tracker u_tracker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .frame_i    (frame_i),
    .room_i     (room),
    .push_o     (push)
  );

  ssegt_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .seg_o  (seg_o)
  );

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for speaker_segment_tracker. A short table of frames
// with typed segments covers reset values, extremes, ties, flushes and two
// segments from one frame. Random speaker runs, silence and noise frames
// follow, under changing register settings and four idle mixes, including
// one chunk past the frame counter limit. Table segments are checked as
// typed, random ones against a local tracker model.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ssegt_pkg::*;

  localparam int NoSpeaker    = NoneSpk;
  localparam int SettleCycles = 6;
  localparam int BlockFrames  = 20;
  localparam int LongFrames   = MaxFrames + 80;
  localparam int CycleLimit   = 200000;

  typedef struct packed {
    logic [NumScores-1:0][ScoreW-1:0] sc;
    logic                             eoc;
  } frame_t;

  typedef struct packed {
    logic                is_cfg;
    cfg_reg_e            reg_idx;
    logic [CfgW-1:0]     data;
    frame_t              frm;
    logic [1:0]          n_exp;
    seg_t                exp_a;
    seg_t                exp_b;
  } plan_row_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we;
  cfg_reg_e        cfg_idx;
  logic [CfgW-1:0] cfg_data;

  ssegt_in_if  frame_if ();
  ssegt_out_if seg_if ();

  speaker_segment_tracker DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .frame_i    (frame_if),
    .seg_o      (seg_if)
  );

  // tracker model state and its register copies
  int frame_cnt;
  int trk_spk;
  int seg_begin;
  int thr;
  int min_len;

  seg_t      seg_q[$];
  plan_row_t directed_plan[$];

  int gap_pct;
  int stall_pct;
  int err_cnt;
  int frames_sent;
  int segs_seen;
  int reg_writes;
  int cycle_cnt;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d segments outstanding", cycle_cnt, seg_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int track_frame(input frame_t f, output seg_t r0, output seg_t r1);
    int   best;
    int   win;
    int   t;
    int   n;
    int   c;
    seg_t r [2];
    r[0] = '0;
    r[1] = '0;
    n    = 0;
    t    = frame_cnt;
    win  = 0;
    best = $signed(f.sc[0]);
    for (c = 1; c < NumClasses; c++) begin
      if ($signed(f.sc[c]) > best) begin
        best = $signed(f.sc[c]);
        win  = c;
      end
    end
    if (best < thr) win = NoSpeaker;
    if (win != trk_spk) begin
      if (trk_spk != NoSpeaker && (t - seg_begin) > min_len) begin
        r[n].start_frame = FrameW'(seg_begin);
        r[n].end_frame   = FrameW'(t);
        r[n].spk         = ClassW'(trk_spk);
        r[n].last        = 1'b0;
        n++;
      end
      trk_spk   = win;
      seg_begin = t;
    end
    if (frame_cnt < MaxFrames) frame_cnt++;
    if (f.eoc) begin
      if (trk_spk != NoSpeaker) begin
        r[n].start_frame = FrameW'(seg_begin);
        r[n].end_frame   = FrameW'(frame_cnt);
        r[n].spk         = ClassW'(trk_spk);
        r[n].last        = 1'b1;
        n++;
      end
      frame_cnt = 0;
      trk_spk   = NoSpeaker;
      seg_begin = 0;
    end
    if (n > 0) r[n-1].last = 1'b1;
    r0 = r[0];
    r1 = r[1];
    return n;
  endfunction

  function automatic frame_t mk_frame(input int fill, input int hot, input int hot_val,
                                      input logic eoc);
    frame_t f;
    int     c;
    for (c = 0; c < NumScores; c++) f.sc[c] = ScoreW'(fill);
    if (hot >= 0) f.sc[hot] = ScoreW'(hot_val);
    f.eoc = eoc;
    return f;
  endfunction

  function automatic seg_t mk_seg(input int s, input int e, input int k, input logic l);
    seg_t g;
    g.start_frame = FrameW'(s);
    g.end_frame   = FrameW'(e);
    g.spk         = ClassW'(k);
    g.last        = l;
    return g;
  endfunction

  function automatic plan_row_t frame_row(input frame_t f, input int n, input seg_t a,
                                          input seg_t b);
    plan_row_t r;
    r       = '0;
    r.frm   = f;
    r.n_exp = 2'(n);
    r.exp_a = a;
    r.exp_b = b;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input cfg_reg_e idx, input int v);
    plan_row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.data    = CfgW'(v);
    return r;
  endfunction

  task automatic settle();
    frame_if.valid <= 1'b0;
    while (seg_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgW-1:0] v);
    settle();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    if (idx == REG_ACT_THRESH) thr = $signed(v);
    else min_len = int'(v[MinW-1:0]);
    reg_writes++;
  endtask

  task automatic send_frame(input frame_t f);
    while ($urandom_range(0, 99) < gap_pct) begin
      frame_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    frame_if.valid        <= 1'b1;
    frame_if.score_0      <= f.sc[0];
    frame_if.score_1      <= f.sc[1];
    frame_if.score_2      <= f.sc[2];
    frame_if.score_3      <= f.sc[3];
    frame_if.score_4      <= f.sc[4];
    frame_if.score_5      <= f.sc[5];
    frame_if.score_6      <= f.sc[6];
    frame_if.end_of_chunk <= f.eoc;
    do @(posedge clk_i); while (!frame_if.ready);
    frames_sent++;
  endtask

  // segment receiver and checker
  initial begin
    seg_t want;
    seg_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && seg_if.valid && seg_if.ready) begin
        if (seg_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected segment start=%0d end=%0d spk=%0d last=%0d",
                     seg_if.seg_start_frame, seg_if.seg_end_frame, seg_if.speaker_class,
                     seg_if.last_of_run);
        end else begin
          want = seg_q.pop_front();
          segs_seen++;
          if (want.start_frame !== seg_if.seg_start_frame ||
              want.end_frame !== seg_if.seg_end_frame ||
              want.spk !== seg_if.speaker_class ||
              want.last !== seg_if.last_of_run) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("segment mismatch: want %0d..%0d spk %0d last %0d, got %0d..%0d spk %0d last %0d",
                       want.start_frame, want.end_frame, want.spk, want.last,
                       seg_if.seg_start_frame, seg_if.seg_end_frame,
                       seg_if.speaker_class, seg_if.last_of_run);
          end
        end
      end
      seg_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    frame_t f;
    seg_t   a;
    seg_t   b;
    int     gap_tab [4];
    int     stall_tab [4];
    int     ph;
    int     blk;
    int     k;
    int     c;
    int     sp;
    int     top;
    int     n_frames;
    int     thr_val;
    int     min_val;
    int     run_spk;
    int     run_left;
    int     chunk_left;
    bit     long_chunk;
    bit     noisy;

    gap_tab   = '{0, 70, 0, 32};
    stall_tab = '{0, 0, 70, 32};
    err_cnt = 0;
    frames_sent = 0;
    segs_seen = 0;
    reg_writes = 0;
    gap_pct = 0;
    stall_pct = 0;
    frame_cnt = 0;
    trk_spk = NoSpeaker;
    seg_begin = 0;
    thr = ThreshReset;
    min_len = MinSegReset;

    rst_ni                <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_idx               <= REG_ACT_THRESH;
    cfg_data              <= '0;
    frame_if.valid        <= 1'b0;
    frame_if.score_0      <= '0;
    frame_if.score_1      <= '0;
    frame_if.score_2      <= '0;
    frame_if.score_3      <= '0;
    frame_if.score_4      <= '0;
    frame_if.score_5      <= '0;
    frame_if.score_6      <= '0;
    frame_if.end_of_chunk <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: threshold -217, min length 29
    directed_plan.push_back(frame_row(mk_frame(-32768, 3, 0, 1'b0), 0, '0, '0));
    directed_plan.push_back(frame_row(mk_frame(-32768, 3, 0, 1'b1), 1,
                                      mk_seg(0, 2, 3, 1'b1), '0));
    directed_plan.push_back(frame_row(mk_frame(-218, -1, 0, 1'b1), 0, '0, '0));
    directed_plan.push_back(frame_row(mk_frame(-217, -1, 0, 1'b1), 1,
                                      mk_seg(0, 1, 0, 1'b1), '0));
    directed_plan.push_back(frame_row(mk_frame(32767, -1, 0, 1'b0), 0, '0, '0));
    directed_plan.push_back(frame_row(mk_frame(32766, 6, 32767, 1'b1), 1,
                                      mk_seg(1, 2, 6, 1'b1), '0));
    directed_plan.push_back(cfg_row(REG_MIN_SEG, 0));
    directed_plan.push_back(frame_row(mk_frame(0, 1, 100, 1'b0), 0, '0, '0));
    directed_plan.push_back(frame_row(mk_frame(0, 2, 100, 1'b0), 1,
                                      mk_seg(0, 1, 1, 1'b1), '0));
    directed_plan.push_back(frame_row(mk_frame(0, 2, 100, 1'b1), 1,
                                      mk_seg(1, 3, 2, 1'b1), '0));
    directed_plan.push_back(frame_row(mk_frame(0, 5, 100, 1'b0), 0, '0, '0));
    directed_plan.push_back(frame_row(mk_frame(0, 4, 100, 1'b1), 2,
                                      mk_seg(0, 1, 5, 1'b0), mk_seg(1, 2, 4, 1'b1)));
    directed_plan.push_back(cfg_row(REG_ACT_THRESH, 32767));
    directed_plan.push_back(frame_row(mk_frame(-1, 3, 32767, 1'b0), 0, '0, '0));
    directed_plan.push_back(frame_row(mk_frame(32766, -1, 0, 1'b0), 1,
                                      mk_seg(0, 1, 3, 1'b1), '0));
    directed_plan.push_back(frame_row(mk_frame(32766, -1, 0, 1'b1), 0, '0, '0));
    directed_plan.push_back(cfg_row(REG_ACT_THRESH, -32768));
    directed_plan.push_back(frame_row(mk_frame(-32768, -1, 0, 1'b0), 0, '0, '0));
    directed_plan.push_back(frame_row(mk_frame(-32768, 6, -32767, 1'b1), 2,
                                      mk_seg(0, 1, 0, 1'b0), mk_seg(1, 2, 6, 1'b1)));
    directed_plan.push_back(cfg_row(REG_MIN_SEG, 1024));
    directed_plan.push_back(frame_row(mk_frame(0, 2, 7, 1'b0), 0, '0, '0));
    directed_plan.push_back(frame_row(mk_frame(0, 5, 7, 1'b1), 1,
                                      mk_seg(1, 2, 5, 1'b1), '0));

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        write_reg(directed_plan[i].reg_idx, directed_plan[i].data);
      end else begin
        send_frame(directed_plan[i].frm);
        void'(track_frame(directed_plan[i].frm, a, b));
        if (directed_plan[i].n_exp > 0) seg_q.push_back(directed_plan[i].exp_a);
        if (directed_plan[i].n_exp > 1) seg_q.push_back(directed_plan[i].exp_b);
      end
    end

    run_spk    = NumClasses;
    run_left   = 0;
    chunk_left = $urandom_range(5, 150);
    for (ph = 0; ph < 4; ph++) begin
      gap_pct   = gap_tab[ph];
      stall_pct = stall_tab[ph];
      for (blk = 0; blk < 5; blk++) begin
        long_chunk = (ph == 0 && blk == 0);
        if (long_chunk) begin
          thr_val = 0;
          min_val = 2;
        end else begin
          case ($urandom_range(0, 5))
            0:       thr_val = -32768;
            1:       thr_val = 32767;
            2:       thr_val = -217;
            3, 4:    thr_val = int'($urandom_range(0, 1200)) - 600;
            default: thr_val = int'($urandom_range(0, 65535)) - 32768;
          endcase
          case ($urandom_range(0, 7))
            0:       min_val = 0;
            1:       min_val = 1024;
            2:       min_val = $urandom_range(0, 1024);
            default: min_val = $urandom_range(0, 12);
          endcase
        end
        write_reg(REG_ACT_THRESH, CfgW'(thr_val));
        write_reg(REG_MIN_SEG, CfgW'(min_val));
        n_frames = long_chunk ? LongFrames : BlockFrames;
        if (long_chunk) chunk_left = LongFrames;

        for (k = 0; k < n_frames; k++) begin
          if (run_left == 0) begin
            run_spk  = $urandom_range(0, NumClasses);
            run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) :
                       $urandom_range(1, (min_len < 50) ? min_len + 10 : 60);
          end
          run_left--;
          noisy = ($urandom_range(0, 7) == 0);
          if (noisy) begin
            for (c = 0; c < NumScores; c++) f.sc[c] = ScoreW'($urandom_range(0, 65535));
          end else if (run_spk == NumClasses && thr > -32768) begin
            for (c = 0; c < NumScores; c++)
              f.sc[c] = ScoreW'(thr - 1 - int'($urandom_range(0, thr + 32767)));
          end else begin
            sp  = (run_spk == NumClasses) ? $urandom_range(0, NumClasses - 1) : run_spk;
            top = thr + int'($urandom_range(0, 32767 - thr));
            for (c = 0; c < NumScores; c++)
              f.sc[c] = ScoreW'(int'($urandom_range(0, top + 32768)) - 32768);
            f.sc[sp] = ScoreW'(top);
            if ($urandom_range(0, 15) == 0) f.sc[$urandom_range(0, NumScores - 1)] = ScoreW'(top);
          end
          chunk_left--;
          f.eoc = (chunk_left == 0) ||
                  (!long_chunk && noisy && $urandom_range(0, 15) == 0);
          if (f.eoc) chunk_left = $urandom_range(5, 150);

          send_frame(f);
          case (track_frame(f, a, b))
            1: seg_q.push_back(a);
            2: begin
              seg_q.push_back(a);
              seg_q.push_back(b);
            end
            default: ;
          endcase
        end
      end
    end

    settle();
    $display("%0d frames sent, %0d segments checked, %0d register writes", frames_sent,
             segs_seen, reg_writes);
    $display("idle mixes: none, sender only, receiver only, both; one chunk ran past %0d frames",
             MaxFrames);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
